>>> rtl/drt_pkg.sv
`default_nettype none
package drt_pkg;

    // field widths of one rectangle
    localparam int COORD_W = 13;
    localparam int SIZE_W  = 12;
    localparam int EDGE_W  = 14;
    localparam int CFG_W   = 12;
    localparam int POS_W   = 4;
    localparam int TOTAL_W = 5;

    // configuration register indexes
    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    // configuration reset values
    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 12'd320;
    localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 12'd200;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_ADDED      = 3'd0,
        ST_COVERED    = 3'd1,
        ST_OFFSCREEN  = 3'd2,
        ST_FULL       = 3'd3,
        ST_READ_OK    = 3'd4,
        ST_READ_EMPTY = 3'd5,
        ST_CLEARED    = 3'd6
    } t_status;

    // left sits in the lowest bits
    typedef struct packed {
        logic        [SIZE_W-1:0]  tall;
        logic        [SIZE_W-1:0]  wide;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] left;
    } t_rect;

    // controller to datapath
    typedef struct packed {
        logic load;       // word accepted: capture it
        logic scan;       // advance the table scan
        logic finish;     // close an add
        logic read_done;  // read data is back
        logic push;       // move result to output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

>>> rtl/dirty_rectangle_table.sv
`default_nettype none
// Ordered table of screen rectangles awaiting redraw. Words on the slave
// stream carry an opcode in tuser (add, read, clear); one result word per
// input word comes out on the master stream with its status in tuser.
// An add scans the stored entries one per cycle through a single-port
// read of the table memory, dropping the new rectangle when an entry
// encloses it, removing entries it strictly encloses and compacting the
// rest in place, then appends it if the table is not full; an offscreen
// add skips the scan. The next word is taken while the previous result
// waits at the output register. Screen size registers are written on the
// cfg channel (index 0 width, 1 height); the user must write them only
// while the block is idle, and the block itself does not enforce this.
module dirty_rectangle_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // slave stream
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [55:0] i_s_tdata,   // rect_left, rect_top, rect_wide, rect_tall, position
    input  wire  [1:0]  i_s_tuser,   // opcode
    // master stream
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [55:0] o_m_tdata,   // out_left, out_top, out_wide, out_tall, entry_total
    output logic [2:0]  o_m_tuser,   // status
    // configuration writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [11:0] i_cfg_data
);
    import drt_pkg::*;

    t_cmd             cmd;
    t_sts             sts;
    t_opcode          op;
    t_rect            in_rect;
    t_status          out_status;
    t_rect            out_rect;
    logic [TOTAL_W-1:0] out_total;

    assign op          = t_opcode'(i_s_tuser);
    assign in_rect     = t_rect'(i_s_tdata[49:0]);
    assign o_cfg_ready = 1'b1;

    drt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_op    (op),
        .i_sts   (sts),
        .o_ready (o_s_tready),
        .o_cmd   (cmd)
    );

    drt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (op),
        .i_rect       (in_rect),
        .i_position   (i_s_tdata[53:50]),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (o_m_tvalid),
        .o_out_status (out_status),
        .o_out_rect   (out_rect),
        .o_out_total  (out_total)
    );

    assign o_m_tdata = {1'b0, out_total, out_rect};
    assign o_m_tuser = out_status;

endmodule
`default_nettype wire

>>> rtl/drt_ctrl.sv
`default_nettype none
module drt_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    input  drt_pkg::t_opcode i_op,
    input  drt_pkg::t_sts   i_sts,
    output logic            o_ready,
    output drt_pkg::t_cmd   o_cmd
);
    import drt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIN,
        S_RDW,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = accept;
                if (accept) begin
                    case (i_op)
                        OP_ADD:  n_state = S_SCAN;
                        OP_READ: n_state = S_RDW;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan = !i_sts.scan_done;
                if (i_sts.scan_done) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_RDW: begin
                o_cmd.read_done = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                o_cmd.push = i_sts.out_free;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

>>> rtl/drt_datapath.sv
`default_nettype none
module drt_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  drt_pkg::t_cmd                i_cmd,
    output drt_pkg::t_sts                o_sts,
    input  drt_pkg::t_opcode             i_op,
    input  drt_pkg::t_rect               i_rect,
    input  wire [drt_pkg::POS_W-1:0]     i_position,
    input  wire                          i_cfg_valid,
    input  wire                          i_cfg_index,
    input  wire [drt_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire                          i_out_ready,
    output logic                         o_out_valid,
    output drt_pkg::t_status             o_out_status,
    output drt_pkg::t_rect               o_out_rect,
    output logic [drt_pkg::TOTAL_W-1:0]  o_out_total
);
    import drt_pkg::*;

    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int RW   = $bits(t_rect);

    // rectangle table
    logic [RW-1:0] r_mem [TABLE_DEPTH];
    logic [RW-1:0] r_rdata;

    // configuration
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;

    // scan state
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_rd;
    logic [CW-1:0]             r_wp;
    logic                      r_pend;
    logic                      r_cover;
    logic                      r_off;
    logic                      r_hit;
    t_rect                     r_new;
    logic signed [EDGE_W-1:0]  r_right;
    logic signed [EDGE_W-1:0]  r_bottom;

    // pending result and output register
    t_status          r_res_status;
    t_rect            r_res_rect;
    logic             r_out_valid;
    t_status          r_out_status;
    t_rect            r_out_rect;
    logic [CW-1:0]    r_out_count;
    logic [CW+TOTAL_W-1:0] total_ext;

    t_rect                    e_rect;
    logic signed [EDGE_W-1:0] e_right;
    logic signed [EDGE_W-1:0] e_bottom;
    logic                     covers;
    logic                     strict;
    logic                     step;
    logic                     eval;
    logic                     full;
    logic                     append;
    logic                     wen;
    logic [IW-1:0]            waddr;
    logic [RW-1:0]            wdata;
    logic [IW-1:0]            raddr;

    // compare the entry just read against the new rectangle
    always_comb begin
        e_rect   = t_rect'(r_rdata);
        e_right  = $signed({e_rect.left[COORD_W-1], e_rect.left})
                 + $signed({2'b00, e_rect.wide});
        e_bottom = $signed({e_rect.top[COORD_W-1], e_rect.top})
                 + $signed({2'b00, e_rect.tall});
        covers   = (e_rect.left <= r_new.left) && (e_rect.top <= r_new.top)
                && (e_right >= r_right) && (e_bottom >= r_bottom);
        strict   = (e_rect.left > r_new.left) && (e_rect.top > r_new.top)
                && (e_right < r_right) && (e_bottom < r_bottom);
    end

    assign step   = i_cmd.scan && !r_off;
    assign eval   = step && r_pend;
    assign full   = (r_wp >= CW'(TABLE_DEPTH));
    assign append = i_cmd.finish && !r_off && !r_cover && !full;

    // write port: compaction copy or append
    assign wen   = (eval && (r_cover || !strict)) || append;
    assign waddr = r_wp[IW-1:0];
    assign wdata = append ? RW'(r_new) : r_rdata;
    assign raddr = i_cmd.load ? IW'(i_position) : r_rd[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (wen) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[raddr];
    end

    assign o_sts.scan_done = r_off || ((r_rd == r_count) && !r_pend);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= SCREEN_WIDTH_RST;
            r_height    <= SCREEN_HEIGHT_RST;
            r_count     <= '0;
            r_rd        <= '0;
            r_wp        <= '0;
            r_pend      <= 1'b0;
            r_cover     <= 1'b0;
            r_off       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_SCREEN_WIDTH) r_width <= i_cfg_data;
                else                                 r_height <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_rd    <= '0;
                r_wp    <= '0;
                r_pend  <= 1'b0;
                r_cover <= 1'b0;
                r_off   <= (i_rect.left >= $signed({1'b0, r_width}))
                        || (i_rect.top >= $signed({1'b0, r_height}));
                if (i_op == OP_CLEAR) r_count <= '0;
            end
            // issue one read and retire one entry per cycle
            if (step) begin
                if (r_rd < r_count) begin
                    r_rd   <= r_rd + 1'b1;
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
                if (eval) begin
                    if (covers) r_cover <= 1'b1;
                    if (r_cover || !strict) r_wp <= r_wp + 1'b1;
                end
            end
            if (i_cmd.finish && !r_off) begin
                r_count <= append ? r_wp + 1'b1 : r_wp;
            end
            if (i_cmd.push)           r_out_valid <= 1'b1;
            else if (i_out_ready)     r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_new    <= i_rect;
            r_right  <= $signed({i_rect.left[COORD_W-1], i_rect.left})
                      + $signed({2'b00, i_rect.wide});
            r_bottom <= $signed({i_rect.top[COORD_W-1], i_rect.top})
                      + $signed({2'b00, i_rect.tall});
            r_hit    <= (CMPW'(i_position) < CMPW'(r_count));
            r_res_rect <= '0;
            case (i_op)
                OP_CLEAR: r_res_status <= ST_CLEARED;
                default:  r_res_status <= ST_READ_EMPTY;
            endcase
        end
        if (i_cmd.finish) begin
            if (r_off)        r_res_status <= ST_OFFSCREEN;
            else if (r_cover) r_res_status <= ST_COVERED;
            else if (full)    r_res_status <= ST_FULL;
            else              r_res_status <= ST_ADDED;
        end
        if (i_cmd.read_done) begin
            r_res_status <= r_hit ? ST_READ_OK : ST_READ_EMPTY;
            r_res_rect   <= r_hit ? e_rect : '0;
        end
        if (i_cmd.push) begin
            r_out_status <= r_res_status;
            r_out_rect   <= r_res_rect;
            r_out_count  <= r_count;
        end
    end

    // entry_total is the low bits of the count
    assign total_ext    = {{TOTAL_W{1'b0}}, r_out_count};
    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_rect   = r_out_rect;
    assign o_out_total  = total_ext[TOTAL_W-1:0];

`ifndef NO_ASSERTIONS
    a_wp_behind_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= r_rd)
        else $error("compaction pointer passed scan pointer");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (r_rd <= r_count))
        else $error("scan pointer beyond stored entries");
    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        append |=> (r_count == $past(r_wp) + 1'b1))
        else $error("append did not grow the table by one");
`endif

endmodule
`default_nettype wire
